// ===== rtl/core/sclp_pkg.sv =====
// Shared types, character codes and lookup functions for the serial command line parser.
// No dependencies; imported by every module of the block.
package sclp_pkg;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_FETCH,
      CTL_EVAL
   } ctl_state_type;

   typedef enum logic [3:0] {
      P_FIRST,
      P_B1,
      P_BRIGHT,
      P_BWS,
      P_BNUM,
      P_C1,
      P_COLOR,
      P_CSP,
      P_SSD,
      P_DSP1,
      P_DSP2
   } parse_state_type;

   typedef enum logic [1:0] {
      KW_BRIGHT,
      KW_COLOR,
      KW_SSD
   } keyword_type;

   localparam logic [1:0] KIND_BRIGHT = 2'd0;
   localparam logic [1:0] KIND_COLOUR = 2'd1;
   localparam logic [1:0] KIND_DIGITS = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = " ";
   localparam logic [7:0] CHAR_PLUS  = "+";
   localparam logic [7:0] CHAR_MINUS = "-";
   localparam logic [7:0] CHAR_B     = "B";
   localparam logic [7:0] CHAR_C     = "C";
   localparam logic [7:0] CHAR_D     = "D";
   localparam logic [7:0] CHAR_S     = "S";

   // last index of each full keyword; trailing space included for BRIGHTNESS and COLOR, not SSD
   localparam logic [3:0] BRIGHT_LAST = 4'd10;
   localparam logic [3:0] COLOR_LAST  = 4'd5;
   localparam logic [3:0] SSD_LAST    = 4'd2;

   localparam logic [8:0] BRIGHT_MAX = 9'd25;

   typedef struct packed {
      logic done;
      logic hit;
   } parse_status_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] brightness;
      logic [2:0] colour;
      logic [7:0] left_char;
      logic [7:0] right_char;
   } parse_result_type;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {["a":"z"]}) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   // {valid, code}: red bit0, green bit1, blue bit2
   function automatic logic [3:0] colour_code(input logic [7:0] c);
      logic [3:0] r;
      case (upcase(c))
         "R":     r = 4'b1_001;
         "G":     r = 4'b1_010;
         "B":     r = 4'b1_100;
         "C":     r = 4'b1_110;
         "M":     r = 4'b1_101;
         "Y":     r = 4'b1_011;
         "W":     r = 4'b1_111;
         default: r = 4'b0_000;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] keyword_char(input keyword_type w, input logic [3:0] idx);
      logic [7:0] r;
      r = CHAR_NUL;
      case (w)
         KW_BRIGHT: begin
            case (idx)
               4'd0:    r = "B";
               4'd1:    r = "R";
               4'd2:    r = "I";
               4'd3:    r = "G";
               4'd4:    r = "H";
               4'd5:    r = "T";
               4'd6:    r = "N";
               4'd7:    r = "E";
               4'd8:    r = "S";
               4'd9:    r = "S";
               4'd10:   r = " ";
               default: r = CHAR_NUL;
            endcase
         end
         KW_COLOR: begin
            case (idx)
               4'd0:    r = "C";
               4'd1:    r = "O";
               4'd2:    r = "L";
               4'd3:    r = "O";
               4'd4:    r = "R";
               4'd5:    r = " ";
               default: r = CHAR_NUL;
            endcase
         end
         KW_SSD: begin
            case (idx)
               4'd0:    r = "S";
               4'd1:    r = "S";
               4'd2:    r = "D";
               default: r = CHAR_NUL;
            endcase
         end
         default: r = CHAR_NUL;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/sclp_parser.sv =====
// Character-at-a-time command recognizer: consumes the stored line one byte per step.
// Depends on sclp_pkg for states, character codes and lookup functions.
module sclp_parser
   import sclp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             init,
   input  logic             step,
   input  logic [7:0]       char_in,
   input  logic [3:0]       char_pos,
   output parse_status_type status,
   output parse_result_type result
);

   parse_state_type state_ff, state_in;
   logic [8:0]      num_ff, num_in;
   logic            digits_ff, digits_in;
   logic [7:0]      left_ff, left_in;
   logic [8:0]      num_next;
   logic [3:0]      col;

   // n*10 + digit; only used while n is still within range
   assign num_next = {num_ff[5:0], 3'b000} + {num_ff[7:0], 1'b0} + {5'b00000, char_in[3:0]};
   assign col      = colour_code(char_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= P_FIRST;
         num_ff    <= '0;
         digits_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         num_ff    <= num_in;
         digits_ff <= digits_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
   end

   always_comb begin
      state_in  = state_ff;
      num_in    = num_ff;
      digits_in = digits_ff;
      left_in   = left_ff;
      status    = '0;
      result    = '0;
      if (init) begin
         state_in  = P_FIRST;
         num_in    = '0;
         digits_in = 1'b0;
      end else if (step) begin
         case (state_ff)
            P_FIRST: begin
               if (char_in == CHAR_B) begin
                  state_in = P_B1;
               end else if (char_in == CHAR_C) begin
                  state_in = P_C1;
               end else if (char_in == CHAR_D) begin
                  state_in = P_DSP1;
               end else if (char_in == CHAR_S) begin
                  state_in = P_SSD;
               end else begin
                  status.done = 1'b1;
               end
            end
            P_B1: begin
               if (char_in == CHAR_SPACE) begin
                  state_in = P_BWS;
               end else if (char_in == keyword_char(KW_BRIGHT, char_pos)) begin
                  state_in = P_BRIGHT;
               end else begin
                  status.done = 1'b1;
               end
            end
            P_BRIGHT: begin
               if (char_in != keyword_char(KW_BRIGHT, char_pos)) begin
                  status.done = 1'b1;
               end else if (char_pos == BRIGHT_LAST) begin
                  state_in = P_BWS;
               end
            end
            P_BWS: begin
               if (is_space(char_in)) begin
                  state_in = P_BWS;
               end else if (char_in == CHAR_PLUS) begin
                  state_in = P_BNUM;
               end else if (is_digit(char_in)) begin
                  num_in    = {5'b00000, char_in[3:0]};
                  digits_in = 1'b1;
                  state_in  = P_BNUM;
               end else begin
                  status.done = 1'b1;
               end
            end
            P_BNUM: begin
               if (is_digit(char_in)) begin
                  digits_in = 1'b1;
                  if (num_ff <= BRIGHT_MAX) begin
                     num_in = num_next;
                  end
               end else begin
                  status.done = 1'b1;
                  if (digits_ff && (num_ff <= BRIGHT_MAX)) begin
                     status.hit        = 1'b1;
                     result.kind       = KIND_BRIGHT;
                     result.brightness = num_ff[4:0];
                  end
               end
            end
            P_C1: begin
               if (char_in == CHAR_SPACE) begin
                  state_in = P_CSP;
               end else if (char_in == keyword_char(KW_COLOR, char_pos)) begin
                  state_in = P_COLOR;
               end else begin
                  status.done = 1'b1;
               end
            end
            P_COLOR: begin
               if (char_in != keyword_char(KW_COLOR, char_pos)) begin
                  status.done = 1'b1;
               end else if (char_pos == COLOR_LAST) begin
                  state_in = P_CSP;
               end
            end
            P_CSP: begin
               if (char_in != CHAR_SPACE) begin
                  status.done = 1'b1;
                  if (col[3]) begin
                     status.hit    = 1'b1;
                     result.kind   = KIND_COLOUR;
                     result.colour = col[2:0];
                  end
               end
            end
            P_SSD: begin
               if (char_in != keyword_char(KW_SSD, char_pos)) begin
                  status.done = 1'b1;
               end else if (char_pos == SSD_LAST) begin
                  state_in = P_DSP1;
               end
            end
            P_DSP1: begin
               if (char_in == CHAR_NUL) begin
                  status.done = 1'b1;
               end else if (char_in != CHAR_SPACE) begin
                  left_in  = upcase(char_in);
                  state_in = P_DSP2;
               end
            end
            P_DSP2: begin
               if (char_in != CHAR_SPACE) begin
                  status.done       = 1'b1;
                  status.hit        = 1'b1;
                  result.kind       = KIND_DIGITS;
                  result.left_char  = left_ff;
                  result.right_char = (char_in == CHAR_NUL) ? left_ff : upcase(char_in);
               end
            end
            default: begin
               status.done = 1'b1;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/serial_command_line_parser.sv =====
// Top level of the serial command line parser: line store, length count and scan sequencer.
// Depends on sclp_pkg and sclp_parser.
//
//   channel   ports                                         handshake
//   request   req_rx_byte                                   start high while busy low
//   result    rsp_kind rsp_brightness rsp_colour            rsp_strobe, one cycle
//             rsp_left_char rsp_right_char
//
// A byte that is not CR or LF is stored (or clears a full line); busy stays low.
// CR or LF on a non-empty line starts a scan of the store: per character a registered store
// read (FETCH), then one parser step (EVAL), stopping at the first byte that decides the
// command, with busy high throughout. The result strobe comes with busy falling.
// Reset empties the line; the store contents are not cleared. Results cannot be stalled.
module serial_command_line_parser
   import sclp_pkg::*;
#(
   parameter int LINE_MAX = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_strobe,
   output logic [1:0] rsp_kind,
   output logic [4:0] rsp_brightness,
   output logic [2:0] rsp_colour,
   output logic [7:0] rsp_left_char,
   output logic [7:0] rsp_right_char
);

   localparam int AW = $clog2(LINE_MAX - 1);
   localparam int LW = $clog2(LINE_MAX);
   localparam logic [LW-1:0] LEN_FULL = LW'(LINE_MAX - 1);

   logic [7:0] store_mem [0:LINE_MAX-2];

   ctl_state_type    ctl_ff, ctl_in;
   logic [LW-1:0]    len_ff, len_in;
   logic [LW-1:0]    pos_ff, pos_in;
   logic [7:0]       rd_data_ff;
   logic             strobe_ff, strobe_in;
   parse_result_type result_ff;
   logic             accept, wr_en, parse_init, parse_step;
   logic [7:0]       scan_char;
   parse_status_type status;
   parse_result_type result;

   assign busy   = (ctl_ff != CTL_IDLE);
   assign accept = start && !busy;
   // bytes past the stored length read as end of content
   assign scan_char = (pos_ff < len_ff) ? rd_data_ff : CHAR_NUL;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[len_ff[AW-1:0]] <= req_rx_byte;
      end
      rd_data_ff <= store_mem[pos_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= CTL_IDLE;
         len_ff    <= '0;
         pos_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ctl_ff    <= ctl_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (strobe_in) begin
         result_ff <= result;
      end
   end

   always_comb begin
      ctl_in     = ctl_ff;
      len_in     = len_ff;
      pos_in     = pos_ff;
      wr_en      = 1'b0;
      parse_init = 1'b0;
      parse_step = 1'b0;
      strobe_in  = 1'b0;
      case (ctl_ff)
         CTL_IDLE: begin
            if (accept) begin
               if ((req_rx_byte == CHAR_CR) || (req_rx_byte == CHAR_LF)) begin
                  if (len_ff != '0) begin
                     parse_init = 1'b1;
                     pos_in     = '0;
                     ctl_in     = CTL_FETCH;
                  end
               end else if (len_ff != LEN_FULL) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + 1'b1;
               end else begin
                  len_in = '0;
               end
            end
         end
         CTL_FETCH: begin
            ctl_in = CTL_EVAL;
         end
         CTL_EVAL: begin
            parse_step = 1'b1;
            if (status.done) begin
               ctl_in    = CTL_IDLE;
               len_in    = '0;
               strobe_in = status.hit;
            end else begin
               pos_in = pos_ff + 1'b1;
               ctl_in = CTL_FETCH;
            end
         end
         default: begin
            ctl_in = CTL_IDLE;
         end
      endcase
   end

   sclp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .init     (parse_init),
      .step     (parse_step),
      .char_in  (scan_char),
      .char_pos (pos_ff[3:0]),
      .status   (status),
      .result   (result)
   );

   assign rsp_strobe     = strobe_ff;
   assign rsp_kind       = result_ff.kind;
   assign rsp_brightness = result_ff.brightness;
   assign rsp_colour     = result_ff.colour;
   assign rsp_left_char  = result_ff.left_char;
   assign rsp_right_char = result_ff.right_char;

endmodule

// ===== rtl/core/sclp_checker.sv =====
// Port-level assertions for the serial command line parser, bound to the top level.
// Depends on sclp_pkg for kind and character codes.
module sclp_checker
   import sclp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [7:0] req_rx_byte,
   input logic       rsp_strobe,
   input logic [1:0] rsp_kind,
   input logic [4:0] rsp_brightness,
   input logic [2:0] rsp_colour,
   input logic [7:0] rsp_left_char,
   input logic [7:0] rsp_right_char
);

   // a result ends a scan: it comes as busy falls
   a_strobe_ends_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe without a finished scan");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in a row");

   // a plain byte is stored without making the block busy
   a_store_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_rx_byte != CHAR_CR) && (req_rx_byte != CHAR_LF)) |=> !busy)
      else $error("stored byte made the block busy");

   a_brightness_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind == KIND_BRIGHT)) |->
         ((rsp_brightness <= 5'd25) && (rsp_colour == 3'd0) &&
          (rsp_left_char == 8'd0) && (rsp_right_char == 8'd0)))
      else $error("bad brightness result");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_kind == KIND_BRIGHT) || (rsp_kind == KIND_COLOUR) ||
                      (rsp_kind == KIND_DIGITS)))
      else $error("unknown result kind");

endmodule

bind serial_command_line_parser sclp_checker u_sclp_checker (.*);

// ===== sim/tb_top.sv =====
// Testbench for serial_command_line_parser: drives received bytes, predicts the decoded commands
// and checks every result strobe against them. Depends on sclp_pkg and the block's RTL.
module tb_top;
   import sclp_pkg::*;

   localparam int LINE_MAX    = 64;
   localparam int LINE_CAP    = LINE_MAX - 1;
   localparam int ITEM_COUNT  = 1550;
   localparam int CALM_ITEMS  = 200;
   localparam int DRAIN_WAIT  = 2 * LINE_MAX + 16;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [7:0] rx;
      int         gap;
      bit         drain;
   } rx_request_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [7:0] req_rx_byte = 8'd0;
   logic       busy;
   logic       rsp_strobe;
   logic [1:0] rsp_kind;
   logic [4:0] rsp_brightness;
   logic [2:0] rsp_colour;
   logic [7:0] rsp_left_char;
   logic [7:0] rsp_right_char;

   rx_request_type   pending_bytes[$];
   parse_result_type expected_cmds[$];
   logic [7:0]       shadow_line[0:LINE_CAP-1];
   int               line_len = 0;
   int               mismatches = 0;
   int               cycle_count = 0;
   int               idle_left = 0;
   int               idle_pct = 0;
   bit               next_drain = 0;

   serial_command_line_parser #(.LINE_MAX(LINE_MAX)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_rx_byte    (req_rx_byte),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_brightness (rsp_brightness),
      .rsp_colour     (rsp_colour),
      .rsp_left_char  (rsp_left_char),
      .rsp_right_char (rsp_right_char)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- line decoder

   function automatic logic [7:0] byte_at(input int i, input int clen);
      return (i < clen) ? shadow_line[i] : CHAR_NUL;
   endfunction

   function automatic bit starts_with(input string w, input int clen);
      for (int k = 0; k < w.len(); k++) begin
         if (byte_at(k, clen) != 8'(w[k])) return 0;
      end
      return 1;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic bit decode_line(input int clen, output parse_result_type r);
      int         i;
      int         n;
      int         digits;
      logic [7:0] c;
      logic [7:0] a;
      logic [7:0] b;
      r = '0;
      if (clen == 0) return 0;
      if (starts_with("B ", clen) || starts_with("BRIGHTNESS ", clen)) begin
         i = starts_with("B ", clen) ? 2 : 11;
         n = 0;
         digits = 0;
         c = byte_at(i, clen);
         while (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            i++;
            c = byte_at(i, clen);
         end
         if (c == CHAR_PLUS) begin
            i++;
            c = byte_at(i, clen);
         end else if (c == CHAR_MINUS) begin
            return 0;
         end
         while (c >= "0" && c <= "9") begin
            // value saturates once it is out of range, so long digit runs stay rejected
            if (n <= 25) n = n * 10 + int'(c - "0");
            digits++;
            i++;
            c = byte_at(i, clen);
         end
         if (digits == 0 || n > 25) return 0;
         r.kind = KIND_BRIGHT;
         r.brightness = n[4:0];
         return 1;
      end
      if (starts_with("C ", clen) || starts_with("COLOR ", clen)) begin
         i = starts_with("C ", clen) ? 2 : 6;
         while (byte_at(i, clen) == CHAR_SPACE) i++;
         r.kind = KIND_COLOUR;
         case (to_upper(byte_at(i, clen)))
            "R":     r.colour = 3'd1;
            "G":     r.colour = 3'd2;
            "B":     r.colour = 3'd4;
            "C":     r.colour = 3'd6;
            "M":     r.colour = 3'd5;
            "Y":     r.colour = 3'd3;
            "W":     r.colour = 3'd7;
            default: return 0;
         endcase
         return 1;
      end
      if (byte_at(0, clen) == CHAR_D || starts_with("SSD", clen)) begin
         i = (byte_at(0, clen) == CHAR_D) ? 1 : 3;
         while (byte_at(i, clen) == CHAR_SPACE) i++;
         a = byte_at(i, clen);
         if (a == CHAR_NUL) return 0;
         i++;
         while (byte_at(i, clen) == CHAR_SPACE) i++;
         b = byte_at(i, clen);
         r.kind = KIND_DIGITS;
         r.left_char = to_upper(a);
         r.right_char = (b == CHAR_NUL) ? to_upper(a) : to_upper(b);
         return 1;
      end
      return 0;
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      parse_result_type r;
      int               clen;
      if (b == CHAR_CR || b == CHAR_LF) begin
         if (line_len > 0) begin
            clen = 0;
            while (clen < line_len && shadow_line[clen] != CHAR_NUL) clen++;
            if (decode_line(clen, r)) expected_cmds.push_back(r);
            line_len = 0;
         end
      end else if (line_len < LINE_CAP) begin
         shadow_line[line_len] = b;
         line_len++;
      end else begin
         line_len = 0;
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void push_byte(input logic [7:0] b);
      rx_request_type t;
      t.rx = b;
      t.gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
      t.drain = next_drain;
      next_drain = 0;
      pending_bytes.push_back(t);
   endfunction

   function automatic void push_text(input string s);
      for (int k = 0; k < s.len(); k++) push_byte(8'(s[k]));
   endfunction

   function automatic void end_line();
      push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
   endfunction

   function automatic logic [7:0] rand_char();
      return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126))
                                         : 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_ws();
      case ($urandom_range(0, 3))
         0:       return CHAR_TAB;
         1:       return 8'd11;
         2:       return 8'd12;
         default: return CHAR_SPACE;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            predict_byte(req_rx_byte);
         end
         if (!start || !busy) begin
            if (idle_left != 0) begin
               start <= 1'b0;
               idle_left <= idle_left - 1;
            end else if (pending_bytes.size() == 0) begin
               start <= 1'b0;
            end else if (pending_bytes[0].drain && (expected_cmds.size() != 0 || busy)) begin
               start <= 1'b0;
            end else if (pending_bytes[0].gap != 0) begin
               idle_left <= pending_bytes[0].gap - 1;
               pending_bytes[0].gap = 0;
               start <= 1'b0;
            end else begin
               req_rx_byte <= pending_bytes[0].rx;
               start <= 1'b1;
               void'(pending_bytes.pop_front());
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch($sformatf("command with none pending: kind %0d", rsp_kind));
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_brightness !== want.brightness)
               report_mismatch($sformatf("brightness %0d, want %0d",
                                         rsp_brightness, want.brightness));
            if (rsp_colour !== want.colour)
               report_mismatch($sformatf("colour %0d, want %0d", rsp_colour, want.colour));
            if (rsp_left_char !== want.left_char)
               report_mismatch($sformatf("left_char %h, want %h",
                                         rsp_left_char, want.left_char));
            if (rsp_right_char !== want.right_char)
               report_mismatch($sformatf("right_char %h, want %h",
                                         rsp_right_char, want.right_char));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      string letters;
      int    sel;
      int    k;
      letters = "RGBCMYWrgbcmyw";

      // directed lines
      push_text("B 25");
      end_line();
      next_drain = 1;
      push_text("C y");
      end_line();
      push_text("Dab");
      end_line();
      push_byte(CHAR_CR);
      push_text("B -3");
      end_line();
      push_byte(CHAR_NUL);
      push_byte(8'hff);
      end_line();

      while (pending_bytes.size() < ITEM_COUNT) begin
         if (pending_bytes.size() > ITEM_COUNT - CALM_ITEMS) idle_pct = 0;
         else idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
         sel = $urandom_range(0, 19);
         if (sel <= 4) begin
            if ($urandom_range(0, 1)) push_text("B ");
            else push_text("BRIGHTNESS ");
            repeat ($urandom_range(0, 3)) push_byte(pick_ws());
            k = $urandom_range(0, 9);
            if (k == 0) push_byte(CHAR_MINUS);
            else if (k < 3) push_byte(CHAR_PLUS);
            k = $urandom_range(0, 9);
            if (k >= 1 && k < 8) push_text($sformatf("%0d", $urandom_range(0, 25)));
            else if (k == 8) push_text($sformatf("0%0d", $urandom_range(0, 25)));
            else if (k == 9) push_text($sformatf("%0d", $urandom_range(26, 99999)));
            if ($urandom_range(0, 3) == 0) push_byte(rand_char());
            end_line();
            if ($urandom_range(0, 39) == 0) next_drain = 1;
         end else if (sel <= 8) begin
            if ($urandom_range(0, 1)) push_text("C ");
            else push_text("COLOR ");
            repeat ($urandom_range(0, 3)) push_byte(CHAR_SPACE);
            if ($urandom_range(0, 9) < 8) push_byte(8'(letters[$urandom_range(0, 13)]));
            else push_byte(rand_char());
            if ($urandom_range(0, 3) == 0) push_byte(rand_char());
            end_line();
            if ($urandom_range(0, 39) == 0) next_drain = 1;
         end else if (sel <= 12) begin
            if ($urandom_range(0, 1)) push_text("D");
            else push_text("SSD");
            repeat ($urandom_range(0, 2)) push_byte(CHAR_SPACE);
            if ($urandom_range(0, 9) != 0) push_byte(rand_char());
            repeat ($urandom_range(0, 2)) push_byte(CHAR_SPACE);
            if ($urandom_range(0, 2) != 0) push_byte(rand_char());
            end_line();
            if ($urandom_range(0, 39) == 0) next_drain = 1;
         end else if (sel <= 14) begin
            // near misses on the keywords
            case ($urandom_range(0, 8))
               0:       push_text("b 5");
               1:       push_text("BR 5");
               2:       push_text("COLO R");
               3:       push_text("SS 12");
               4:       push_text("c r");
               5:       push_text("BRIGHTNESS5");
               6:       push_text("Cr");
               7:       push_text("S D1");
               default: push_text("d1");
            endcase
            end_line();
         end else if (sel <= 16) begin
            repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
            end_line();
         end else if (sel == 17) begin
            // zero byte cuts the line content short
            case ($urandom_range(0, 3))
               0:       push_text("B 1");
               1:       push_text("C g");
               2:       push_text("D");
               default: push_text("SSD 4");
            endcase
            push_byte(CHAR_NUL);
            push_byte(rand_char());
            push_byte(rand_char());
            end_line();
         end else if (sel == 18) begin
            k = $urandom_range(0, 2);
            if (k == 0) begin
               // exactly a full store
               push_text("B ");
               repeat (LINE_CAP - 3) push_byte(pick_ws());
               push_byte("7");
            end else if (k == 1) begin
               // overflow clears the line and drops the byte, then a fresh command
               repeat (LINE_CAP + 1) push_byte(8'($urandom_range(32, 126)));
               push_text("C b");
            end else begin
               push_text("SSD");
               repeat (LINE_CAP - 5) push_byte(CHAR_SPACE);
               push_byte(8'($urandom_range(32, 126)));
               push_byte(8'($urandom_range(32, 126)));
            end
            end_line();
         end else begin
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || start) @(posedge clock);
      while (expected_cmds.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_cmds.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
